### rtl/olr_pkg.sv
// Package with the shared constants, types and codes of the ordered key list.
`timescale 1ns / 1ps
package olr_pkg;

	// List geometry.
	localparam int CAPACITY = 16;
	localparam int KEY_BITS = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int TALLY_W  = 32;
	localparam int STAT_W   = 3;

	// Request actions.
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		STAT_INSERTED  = 3'd0,
		STAT_REMOVED   = 3'd1,
		STAT_EMPTY     = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_FULL      = 3'd4
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_SEARCH,
		CTL_UPDATE
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic search;
		logic update;
	} ctl_cmd_t;

endpackage

### rtl/olr_ctrl.sv
// Controller state machine that sequences one request through search and update.
`timescale 1ns / 1ps
module olr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output olr_pkg::ctl_cmd_t cmd
);
	import olr_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		busy       = 1'b1;
		unique case (state_q)
			CTL_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = CTL_SEARCH;
				end
			end
			CTL_SEARCH: begin
				cmd.search = 1'b1;
				state_d    = CTL_UPDATE;
			end
			CTL_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = CTL_IDLE;
			end
			default: begin
				state_d = CTL_IDLE;
			end
		endcase
	end

endmodule

### rtl/olr_dp.sv
// Datapath: a row of key cells with per-cell compare, collapse on remove, and result registers.
`timescale 1ns / 1ps
module olr_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  olr_pkg::ctl_cmd_t             cmd,
	input  logic                          action,
	input  logic [olr_pkg::KEY_BITS-1:0]  key,
	output logic                          done,
	output logic [olr_pkg::STAT_W-1:0]    status,
	output logic [olr_pkg::KEY_BITS-1:0]  removed_key,
	output logic [olr_pkg::CNT_W-1:0]     live_count,
	output logic [olr_pkg::TALLY_W-1:0]   inserts_total
);
	import olr_pkg::*;

	// Captured request.
	logic                req_action_q;
	logic [KEY_BITS-1:0] req_key_q;

	// List state.
	logic [KEY_BITS-1:0] cells_q [CAPACITY];
	logic [CNT_W-1:0]    count_q;
	logic [TALLY_W-1:0]  tally_q;
	logic [CAPACITY-1:0] match_q;

	// Result registers.
	logic                done_q;
	status_t             status_q;
	logic [KEY_BITS-1:0] removed_key_q;
	logic [CNT_W-1:0]    live_count_q;

	// Update decisions.
	logic [IDX_W-1:0]    last_idx;
	logic [IDX_W-1:0]    first_idx;
	logic                first_found;
	logic [IDX_W-1:0]    pos;
	logic                hit;
	logic                list_full;
	logic                list_empty;
	logic                do_insert;
	logic                do_remove;
	status_t             status_d;
	logic [KEY_BITS-1:0] removed_d;
	logic [CNT_W-1:0]    count_d;
	logic [TALLY_W-1:0]  tally_d;

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_action_q <= action;
			req_key_q    <= key;
		end
	end

	// Per-cell compare against the requested key, limited to live cells.
	always_ff @(posedge clk) begin
		if (cmd.search) begin
			for (int i = 0; i < CAPACITY; i++) begin
				match_q[i] <= (cells_q[i] == req_key_q) && (CNT_W'(i) < count_q);
			end
		end
	end

	// Earliest matching cell.
	always_comb begin
		first_idx   = '0;
		first_found = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (match_q[i] && !first_found) begin
				first_idx   = IDX_W'(i);
				first_found = 1'b1;
			end
		end
	end

	// Position choice: head first, then tail, then the earliest match.
	assign last_idx = IDX_W'(count_q - CNT_W'(1));
	assign hit      = |match_q;

	always_comb begin
		priority if (match_q[0]) begin
			pos = '0;
		end else if (match_q[last_idx]) begin
			pos = last_idx;
		end else begin
			pos = first_idx;
		end
	end

	// Outcome of the request.
	assign list_full  = (count_q == CNT_W'(CAPACITY));
	assign list_empty = (count_q == '0);
	assign do_insert  = (req_action_q == ACT_INSERT) && !list_full;
	assign do_remove  = (req_action_q == ACT_REMOVE) && !list_empty && hit;

	always_comb begin
		status_d  = STAT_INSERTED;
		removed_d = '0;
		count_d   = count_q;
		tally_d   = tally_q;
		if (req_action_q == ACT_INSERT) begin
			if (list_full) begin
				status_d = STAT_FULL;
			end else begin
				status_d = STAT_INSERTED;
				count_d  = count_q + CNT_W'(1);
				tally_d  = tally_q + TALLY_W'(1);
			end
		end else if (list_empty) begin
			status_d = STAT_EMPTY;
		end else if (!hit) begin
			status_d = STAT_NOT_FOUND;
		end else begin
			status_d  = STAT_REMOVED;
			removed_d = cells_q[pos];
			count_d   = count_q - CNT_W'(1);
		end
	end

	// Cell row: append at the tail, or collapse the cells above the removed one.
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			if (do_insert) begin
				cells_q[count_q[IDX_W-1:0]] <= req_key_q;
			end else if (do_remove) begin
				for (int i = 0; i < CAPACITY - 1; i++) begin
					if (IDX_W'(i) >= pos) begin
						cells_q[i] <= cells_q[i + 1];
					end
				end
			end
		end
	end

	// Count and insert tally.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tally_q <= '0;
		end else if (cmd.update) begin
			count_q <= count_d;
			tally_q <= tally_d;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.update;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			status_q      <= status_d;
			removed_key_q <= removed_d;
			live_count_q  <= count_d;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign removed_key   = removed_key_q;
	assign live_count    = live_count_q;
	assign inserts_total = tally_q;

endmodule

### rtl/ordered_list_remove_by_key.sv
// Top level of the ordered key list with insert at the tail and remove by key.
`timescale 1ns / 1ps
// Usage:
// A request is taken at a rising clock edge where start is high and busy is
// low; action and key are sampled at that edge. Action zero appends key at
// the tail, action one removes the entry holding key: the head is tried
// first, then the tail, then the earliest match, and the others keep order.
// Each request gives exactly one result, shown for a single cycle with done
// high: status, removed_key (zero unless removed), live_count after the
// request and inserts_total, the wrapping count of accepted inserts.
// Sequence: after the accepting edge the controller passes the search state,
// then the update state, and done rises with the registered result.
// A new request is not taken until the previous one is through, as the
// controller walks through capture, per-cell compare and the update of the
// cell row; busy is high during search and update, and a new start is taken
// in the cycle that shows the previous result.
// Reset clears the list count, the insert total and the result strobe; the
// cells themselves are not cleared since only live cells are ever read.
// The receiver cannot stall: it must take each result in its done cycle.
module ordered_list_remove_by_key (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          action,
	input  logic [olr_pkg::KEY_BITS-1:0]  key,
	output logic                          done,
	output logic [olr_pkg::STAT_W-1:0]    status,
	output logic [olr_pkg::KEY_BITS-1:0]  removed_key,
	output logic [olr_pkg::CNT_W-1:0]     live_count,
	output logic [olr_pkg::TALLY_W-1:0]   inserts_total
);
	import olr_pkg::*;

	ctl_cmd_t cmd;

	// Sequencer.
	olr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Cell row and result registers.
	olr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.action        (action),
		.key           (key),
		.done          (done),
		.status        (status),
		.removed_key   (removed_key),
		.live_count    (live_count),
		.inserts_total (inserts_total)
	);

endmodule
